[rtl/arc_pkg.sv]
// shared types and constants of the arp resolver cache
package arc_pkg;
	localparam int CacheEntriesDef   = 16;
	localparam int PendingEntriesDef = 8;
	localparam int CfgIdxW           = 2;
	localparam int CfgDataW          = 48;

	typedef enum logic [1:0] {
		CMD_ARP  = 2'd0,
		CMD_PKT  = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_REJECT  = 3'd0,
		ACT_LEARN   = 3'd1,
		ACT_RELEASE = 3'd2,
		ACT_REPLY   = 3'd3,
		ACT_FORWARD = 3'd4,
		ACT_HOLD    = 3'd5,
		ACT_DROP_PD = 3'd6,
		ACT_DROP_FL = 3'd7
	} action_t;

	localparam logic [CfgIdxW-1:0] REG_LOCAL_IP  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_LOCAL_MAC = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ENTRY_LT  = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_PEND_LT   = 2'd3;

	localparam logic [15:0] ARP_HW_ETH   = 16'h0001;
	localparam logic [15:0] ARP_PROTO_IP = 16'h0800;
	localparam logic [7:0]  ARP_HLEN     = 8'd6;
	localparam logic [7:0]  ARP_PLEN     = 8'd4;
	localparam logic [15:0] OP_REQUEST   = 16'd1;
	localparam logic [15:0] OP_REPLY     = 16'd2;
	localparam logic [10:0] ARP_HDR_LEN  = 11'd28;
	localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
endpackage

[rtl/arc_in_if.sv]
// input channel: arp header, outbound packet or tick
interface arc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [10:0] frame_len;
	logic [15:0] hw_type;
	logic [15:0] proto_type;
	logic [7:0]  hw_addr_len;
	logic [7:0]  proto_addr_len;
	logic [15:0] arp_opcode;
	logic [31:0] arp_src_ip;
	logic [47:0] arp_src_mac;
	logic [31:0] arp_dst_ip;
	logic [31:0] next_hop_ip;
	logic [7:0]  packet_tag;

	modport source (output valid, cmd, frame_len, hw_type, proto_type, hw_addr_len,
		proto_addr_len, arp_opcode, arp_src_ip, arp_src_mac, arp_dst_ip, next_hop_ip,
		packet_tag, input ready);
	modport sink (input valid, cmd, frame_len, hw_type, proto_type, hw_addr_len,
		proto_addr_len, arp_opcode, arp_src_ip, arp_src_mac, arp_dst_ip, next_hop_ip,
		packet_tag, output ready);
endinterface

[rtl/arc_out_if.sv]
// result channel: action with addresses and tag
interface arc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [47:0] dest_mac;
	logic [31:0] dest_ip;
	logic [7:0]  out_tag;

	modport source (output valid, action, dest_mac, dest_ip, out_tag, input ready);
	modport sink (input valid, action, dest_mac, dest_ip, out_tag, output ready);
endinterface

[rtl/arp_resolver_cache_unit.sv]
// arp resolver cache top level: sequencer with one shared entry compare/age unit
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | cmd, arp header fields, next hop, tag
//  out_ch  | out | valid/ready      | action, dest_mac, dest_ip, out_tag
//  cfg     | in  | cfg_we           | cfg_idx, cfg_data
// an arp header or outbound packet is accepted in idle, scanned through the cache table and then
// the pending table, decided and emitted; the next item is accepted only once it is back in idle.
// cache and pending tables are walked one entry a cycle through one compare unit.
// a tick walks both tables and updates ages and valid bits one entry a cycle, then returns to idle
// with no beat; a rejected header skips both scans, and cmd 3 is ignored in idle.
// a beat still waiting on out_ch holds the next item at its decide step; reset clears valid
// bits, the local ip and the sequencer, and sets the entry and pending lifetimes to 60 and 1.
module arp_resolver_cache_unit
	import arc_pkg::*;
#(
	parameter int CACHE_ENTRIES   = CacheEntriesDef,
	parameter int PENDING_ENTRIES = PendingEntriesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	arc_in_if.sink              in_ch,
	arc_out_if.source           out_ch,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data
);
	localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CSCAN, ST_PSCAN, ST_DECIDE, ST_EMIT
	} state_t;

	state_t state_q;
	logic [31:0] local_ip_q;
	logic [15:0] entry_lt_q, pend_lt_q;

	logic [CACHE_ENTRIES-1:0]   cvalid_q;
	logic [31:0] cip_q  [CACHE_ENTRIES];
	logic [47:0] cmac_q [CACHE_ENTRIES];
	logic [15:0] cage_q [CACHE_ENTRIES];
	logic [PENDING_ENTRIES-1:0] pvalid_q;
	logic [31:0] pip_q  [PENDING_ENTRIES];
	logic [7:0]  ptag_q [PENDING_ENTRIES];
	logic [15:0] page_q [PENDING_ENTRIES];

	// latched item
	logic [1:0]  cmd_q;
	logic        hdr_ok_q;
	logic        is_req_q;
	logic [31:0] ip_q;
	logic [47:0] smac_q;
	logic [31:0] tip_q;
	logic [7:0]  tag_q;

	// scan results
	logic [CW:0] cidx_q;
	logic [PW:0] pidx_q;
	logic        chit_q, cfree_q, phit_q, pfree_q;
	logic [CW-1:0] chit_i_q, cfree_i_q, cold_i_q;
	logic [PW-1:0] phit_i_q, pfree_i_q;
	logic [15:0] cold_age_q;
	logic [47:0] hit_mac_q;
	logic [7:0]  hit_tag_q;

	logic        ovalid_q;
	logic [2:0]  oact_q;
	logic [47:0] omac_q;
	logic [31:0] oip_q;
	logic [7:0]  otag_q;

	// shared entry unit
	logic [CW-1:0] ci;
	logic [PW-1:0] pi;
	logic        c_match, p_match;
	logic [15:0] c_age_inc, p_age_inc;
	assign ci = cidx_q[CW-1:0];
	assign pi = pidx_q[PW-1:0];
	assign c_match = cvalid_q[ci] && (cip_q[ci] == ip_q);
	assign p_match = pvalid_q[pi] && (pip_q[pi] == ip_q);
	assign c_age_inc = (cage_q[ci] == 16'hFFFF) ? cage_q[ci] : cage_q[ci] + 16'd1;
	assign p_age_inc = (page_q[pi] == 16'hFFFF) ? page_q[pi] : page_q[pi] + 16'd1;

	logic hdr_ok;
	assign hdr_ok = (in_ch.frame_len >= ARP_HDR_LEN) && (in_ch.hw_type == ARP_HW_ETH)
		&& (in_ch.proto_type == ARP_PROTO_IP) && (in_ch.hw_addr_len == ARP_HLEN)
		&& (in_ch.proto_addr_len == ARP_PLEN)
		&& ((in_ch.arp_opcode == OP_REQUEST) || (in_ch.arp_opcode == OP_REPLY));

	logic out_free;
	assign out_free = !ovalid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	assign out_ch.valid    = ovalid_q;
	assign out_ch.action   = oact_q;
	assign out_ch.dest_mac = omac_q;
	assign out_ch.dest_ip  = oip_q;
	assign out_ch.out_tag  = otag_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= '0;
			entry_lt_q  <= 16'd60;
			pend_lt_q   <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LOCAL_IP:  local_ip_q  <= cfg_data[31:0];
				// own mac only sources replies, which are built downstream
				REG_LOCAL_MAC: ;
				REG_ENTRY_LT:  entry_lt_q  <= cfg_data[15:0];
				REG_PEND_LT:   pend_lt_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// tables (payload, no reset)
	always_ff @(posedge clk) begin
		if (state_q == ST_CSCAN && cmd_q == CMD_TICK && cvalid_q[ci])
			cage_q[ci] <= c_age_inc;
		if (state_q == ST_PSCAN && cmd_q == CMD_TICK && pvalid_q[pi])
			page_q[pi] <= p_age_inc;
		if (state_q == ST_DECIDE && out_free && cmd_q == CMD_ARP && hdr_ok_q) begin
			if (chit_q) begin
				cmac_q[chit_i_q] <= smac_q;
				cage_q[chit_i_q] <= '0;
			end else if (cfree_q) begin
				cip_q[cfree_i_q]  <= ip_q;
				cmac_q[cfree_i_q] <= smac_q;
				cage_q[cfree_i_q] <= '0;
			end else begin
				cip_q[cold_i_q]  <= ip_q;
				cmac_q[cold_i_q] <= smac_q;
				cage_q[cold_i_q] <= '0;
			end
		end
		if (state_q == ST_DECIDE && out_free && cmd_q == CMD_PKT && !chit_q && !phit_q
				&& pfree_q) begin
			pip_q[pfree_i_q]  <= ip_q;
			ptag_q[pfree_i_q] <= tag_q;
			page_q[pfree_i_q] <= '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cvalid_q <= '0;
			pvalid_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT)
				ovalid_q <= 1'b1;
			else if (ovalid_q && out_ch.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						cmd_q    <= in_ch.cmd;
						hdr_ok_q <= hdr_ok;
						is_req_q <= (in_ch.arp_opcode == OP_REQUEST);
						ip_q     <= (in_ch.cmd == CMD_PKT) ? in_ch.next_hop_ip
							: in_ch.arp_src_ip;
						smac_q   <= in_ch.arp_src_mac;
						tip_q    <= in_ch.arp_dst_ip;
						tag_q    <= in_ch.packet_tag;
						cidx_q   <= '0;
						pidx_q   <= '0;
						chit_q   <= 1'b0;
						cfree_q  <= 1'b0;
						phit_q   <= 1'b0;
						pfree_q  <= 1'b0;
						cold_i_q <= '0;
						cold_age_q <= '0;
						if (in_ch.cmd == CMD_NONE)
							state_q <= ST_IDLE;
						else if (in_ch.cmd == CMD_ARP && !hdr_ok)
							state_q <= ST_DECIDE;
						else
							state_q <= ST_CSCAN;
					end
				end
				ST_CSCAN: begin
					if (cmd_q == CMD_TICK) begin
						if (cvalid_q[ci] && c_age_inc >= entry_lt_q)
							cvalid_q[ci] <= 1'b0;
					end else begin
						if (c_match && !chit_q) begin
							chit_q    <= 1'b1;
							chit_i_q  <= ci;
							hit_mac_q <= cmac_q[ci];
						end
						if (!cvalid_q[ci] && !cfree_q) begin
							cfree_q   <= 1'b1;
							cfree_i_q <= ci;
						end
						if (cidx_q == '0 || cage_q[ci] > cold_age_q) begin
							cold_i_q   <= ci;
							cold_age_q <= cage_q[ci];
						end
					end
					if (cidx_q == (CW+1)'(CACHE_ENTRIES - 1))
						state_q <= ST_PSCAN;
					cidx_q <= cidx_q + 1'b1;
				end
				ST_PSCAN: begin
					if (cmd_q == CMD_TICK) begin
						if (pvalid_q[pi] && p_age_inc >= pend_lt_q)
							pvalid_q[pi] <= 1'b0;
					end else begin
						if (p_match && !phit_q) begin
							phit_q    <= 1'b1;
							phit_i_q  <= pi;
							hit_tag_q <= ptag_q[pi];
						end
						if (!pvalid_q[pi] && !pfree_q) begin
							pfree_q   <= 1'b1;
							pfree_i_q <= pi;
						end
					end
					if (pidx_q == (PW+1)'(PENDING_ENTRIES - 1))
						state_q <= (cmd_q == CMD_TICK) ? ST_IDLE : ST_DECIDE;
					pidx_q <= pidx_q + 1'b1;
				end
				ST_DECIDE: begin
					// output registers reload only once the old beat has left
					if (out_free) begin
						state_q <= ST_EMIT;
						if (cmd_q == CMD_ARP) begin
							if (!hdr_ok_q) begin
								oact_q <= ACT_REJECT;
								omac_q <= '0;
								oip_q  <= '0;
								otag_q <= '0;
							end else begin
								omac_q <= smac_q;
								oip_q  <= ip_q;
								if (chit_q)
									cvalid_q[chit_i_q] <= 1'b1;
								else if (cfree_q)
									cvalid_q[cfree_i_q] <= 1'b1;
								else
									cvalid_q[cold_i_q] <= 1'b1;
								if (phit_q) begin
									pvalid_q[phit_i_q] <= 1'b0;
									oact_q <= ACT_RELEASE;
									otag_q <= hit_tag_q;
								end else if (is_req_q && tip_q == local_ip_q) begin
									oact_q <= ACT_REPLY;
									otag_q <= '0;
								end else begin
									oact_q <= ACT_LEARN;
									otag_q <= '0;
								end
							end
						end else begin
							oip_q  <= ip_q;
							otag_q <= tag_q;
							if (chit_q) begin
								oact_q <= ACT_FORWARD;
								omac_q <= hit_mac_q;
							end else if (phit_q) begin
								oact_q <= ACT_DROP_PD;
								omac_q <= '0;
							end else if (pfree_q) begin
								pvalid_q[pfree_i_q] <= 1'b1;
								oact_q <= ACT_HOLD;
								omac_q <= MAC_BCAST;
							end else begin
								oact_q <= ACT_DROP_FL;
								omac_q <= '0;
							end
						end
					end
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[tb/arc_tb_if.sv]
// channel interfaces used by the testbench come from the rtl; this file holds the stimulus item and result types
package arc_tb_pkg;
	import arc_pkg::*;

	typedef struct packed {
		cmd_t        cmd;
		logic [10:0] frame_len;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_addr_len;
		logic [7:0]  proto_addr_len;
		logic [15:0] arp_opcode;
		logic [31:0] arp_src_ip;
		logic [47:0] arp_src_mac;
		logic [31:0] arp_dst_ip;
		logic [31:0] next_hop_ip;
		logic [7:0]  packet_tag;
	} arc_item_t;

	typedef struct packed {
		action_t     action;
		logic [47:0] dest_mac;
		logic [31:0] dest_ip;
		logic [7:0]  out_tag;
	} arc_result_t;
endpackage

[tb/testbench.sv]
// testbench of the arp resolver cache: directed and random traffic checked against a predictor
module testbench;
	import arc_pkg::*;
	import arc_tb_pkg::*;

	localparam int NC = CacheEntriesDef;
	localparam int NP = PendingEntriesDef;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	bit failed = 1'b0;
	bit calm = 1'b0;

	arc_in_if in_ch();
	arc_out_if out_ch();

	arp_resolver_cache_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [31:0] my_ip;
	logic [47:0] my_mac;
	logic [15:0] cache_life, pend_life;
	bit          c_vld[NC];
	logic [31:0] c_ip[NC];
	logic [47:0] c_mac[NC];
	logic [15:0] c_age[NC];
	bit          p_vld[NP];
	logic [31:0] p_ip[NP];
	logic [7:0]  p_tag[NP];
	logic [15:0] p_age[NP];
	arc_result_t resolved_q[$];
	// a small pool of ips, so random traffic hits the tables
	logic [31:0] ip_pool[8];

	task automatic model_reset();
		my_ip = '0; my_mac = '0; cache_life = 16'd60; pend_life = 16'd1;
		for (int i = 0; i < NC; i++) c_vld[i] = 0;
		for (int i = 0; i < NP; i++) p_vld[i] = 0;
	endtask

	function automatic int cache_lookup(logic [31:0] ip);
		for (int i = 0; i < NC; i++) if (c_vld[i] && c_ip[i] == ip) return i;
		return -1;
	endfunction

	function automatic int pend_lookup(logic [31:0] ip);
		for (int i = 0; i < NP; i++) if (p_vld[i] && p_ip[i] == ip) return i;
		return -1;
	endfunction

	task automatic learn_pair(logic [31:0] ip, logic [47:0] mac);
		int s;
		s = cache_lookup(ip);
		if (s < 0)
			for (int i = 0; i < NC; i++) if (!c_vld[i]) begin s = i; break; end
		if (s < 0) begin
			// full: evict oldest, lowest index on ties
			s = 0;
			for (int i = 1; i < NC; i++) if (c_age[i] > c_age[s]) s = i;
		end
		c_vld[s] = 1; c_ip[s] = ip; c_mac[s] = mac; c_age[s] = '0;
	endtask

	task automatic predict_resolution(arc_item_t it);
		arc_result_t r;
		int c, p;
		bit found;
		case (it.cmd)
			CMD_ARP: begin
				if (it.frame_len < ARP_HDR_LEN || it.hw_type != ARP_HW_ETH ||
						it.proto_type != ARP_PROTO_IP || it.hw_addr_len != ARP_HLEN ||
						it.proto_addr_len != ARP_PLEN ||
						(it.arp_opcode != OP_REQUEST && it.arp_opcode != OP_REPLY)) begin
					r = '{ACT_REJECT, '0, '0, '0};
				end else begin
					learn_pair(it.arp_src_ip, it.arp_src_mac);
					p = pend_lookup(it.arp_src_ip);
					if (p >= 0) begin
						p_vld[p] = 0;
						r = '{ACT_RELEASE, it.arp_src_mac, it.arp_src_ip, p_tag[p]};
					end else if (it.arp_opcode == OP_REQUEST && it.arp_dst_ip == my_ip)
						r = '{ACT_REPLY, it.arp_src_mac, it.arp_src_ip, '0};
					else
						r = '{ACT_LEARN, it.arp_src_mac, it.arp_src_ip, '0};
				end
				resolved_q.push_back(r);
			end
			CMD_PKT: begin
				c = cache_lookup(it.next_hop_ip);
				if (c >= 0) r = '{ACT_FORWARD, c_mac[c], it.next_hop_ip, it.packet_tag};
				else if (pend_lookup(it.next_hop_ip) >= 0)
					r = '{ACT_DROP_PD, '0, it.next_hop_ip, it.packet_tag};
				else begin
					found = 0;
					for (int i = 0; i < NP; i++) if (!p_vld[i]) begin
						p_vld[i] = 1; p_ip[i] = it.next_hop_ip;
						p_tag[i] = it.packet_tag; p_age[i] = '0;
						found = 1; break;
					end
					if (found) r = '{ACT_HOLD, MAC_BCAST, it.next_hop_ip, it.packet_tag};
					else r = '{ACT_DROP_FL, '0, it.next_hop_ip, it.packet_tag};
				end
				resolved_q.push_back(r);
			end
			CMD_TICK: begin
				for (int i = 0; i < NC; i++) if (c_vld[i]) begin
					if (c_age[i] != 16'hFFFF) c_age[i]++;
					if (c_age[i] >= cache_life) c_vld[i] = 0;
				end
				for (int i = 0; i < NP; i++) if (p_vld[i]) begin
					if (p_age[i] != 16'hFFFF) p_age[i]++;
					if (p_age[i] >= pend_life) p_vld[i] = 0;
				end
			end
			default: ;
		endcase
	endtask

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 13);
	endfunction

	initial begin
		in_ch.valid = 0;
		{in_ch.cmd, in_ch.frame_len, in_ch.hw_type, in_ch.proto_type, in_ch.hw_addr_len,
			in_ch.proto_addr_len, in_ch.arp_opcode, in_ch.arp_src_ip, in_ch.arp_src_mac,
			in_ch.arp_dst_ip, in_ch.next_hop_ip, in_ch.packet_tag} = '0;
	end

	task automatic send_item(arc_item_t it);
		while (idle_now()) @(negedge clk);
		in_ch.valid = 1'b1;
		{in_ch.cmd, in_ch.frame_len, in_ch.hw_type, in_ch.proto_type, in_ch.hw_addr_len,
			in_ch.proto_addr_len, in_ch.arp_opcode, in_ch.arp_src_ip, in_ch.arp_src_mac,
			in_ch.arp_dst_ip, in_ch.next_hop_ip, in_ch.packet_tag} = it;
		do @(posedge clk); while (!in_ch.ready);
		predict_resolution(it);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// result checker and receiver stalls
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		arc_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (resolved_q.size() == 0) begin
				$error("unexpected result action=%0d", out_ch.action);
				failed = 1;
			end else begin
				exp_r = resolved_q.pop_front();
				if (out_ch.action !== exp_r.action) begin
					$error("action exp %0d got %0d", exp_r.action, out_ch.action); failed = 1;
				end
				if (out_ch.dest_mac !== exp_r.dest_mac) begin
					$error("dest_mac exp %h got %h", exp_r.dest_mac, out_ch.dest_mac); failed = 1;
				end
				if (out_ch.dest_ip !== exp_r.dest_ip) begin
					$error("dest_ip exp %h got %h", exp_r.dest_ip, out_ch.dest_ip); failed = 1;
				end
				if (out_ch.out_tag !== exp_r.out_tag) begin
					$error("out_tag exp %h got %h", exp_r.out_tag, out_ch.out_tag); failed = 1;
				end
			end
		end
	end

	task automatic drain();
		while (resolved_q.size() != 0) @(negedge clk);
		// a trailing tick produces no result; let it finish
		repeat (3 * (NC + NP + 3)) @(negedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_we = 1'b1; cfg_idx = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LOCAL_IP:  my_ip = val[31:0];
			REG_LOCAL_MAC: my_mac = val[47:0];
			REG_ENTRY_LT:  cache_life = val[15:0];
			REG_PEND_LT:   pend_life = val[15:0];
			default: ;
		endcase
	endtask

	function automatic arc_item_t good_arp(logic [15:0] op, logic [31:0] sip,
			logic [47:0] smac, logic [31:0] tip);
		arc_item_t it;
		it = '0;
		it.cmd = CMD_ARP; it.frame_len = ARP_HDR_LEN; it.hw_type = ARP_HW_ETH;
		it.proto_type = ARP_PROTO_IP; it.hw_addr_len = ARP_HLEN; it.proto_addr_len = ARP_PLEN;
		it.arp_opcode = op; it.arp_src_ip = sip; it.arp_src_mac = smac; it.arp_dst_ip = tip;
		return it;
	endfunction

	function automatic arc_item_t pkt(logic [31:0] ip, logic [7:0] tag);
		arc_item_t it;
		it = '0;
		it.cmd = CMD_PKT; it.next_hop_ip = ip; it.packet_tag = tag;
		return it;
	endfunction

	function automatic arc_item_t tick();
		arc_item_t it;
		it = '0;
		it.cmd = CMD_TICK;
		return it;
	endfunction

	task automatic test_directed();
		arc_item_t it;
		write_reg(REG_LOCAL_IP, 48'hFFFF_FFFF);
		write_reg(REG_LOCAL_MAC, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_ENTRY_LT, 48'd3);
		write_reg(REG_PEND_LT, 48'd2);
		send_item(pkt(32'hFFFF_FFFF, 8'hFF));               // hold and request
		send_item(pkt(32'hFFFF_FFFF, 8'h00));               // drop pending
		send_item(good_arp(OP_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0)); // release
		send_item(pkt(32'hFFFF_FFFF, 8'h5A));               // forward
		send_item(good_arp(OP_REQUEST, 32'h0, 48'h0, 32'hFFFF_FFFF)); // reply
		send_item(good_arp(OP_REQUEST, 32'h1, 48'h1234, 32'h0));      // learn only
		send_item(good_arp(OP_REPLY, 32'h1, 48'h5678, 32'hFFFF_FFFF)); // relearn
		it = good_arp(OP_REQUEST, 32'h2, 48'h2, 32'h2); it.frame_len = 11'd27; send_item(it);
		it.frame_len = 11'h7FF; it.hw_type = 16'hFFFF; send_item(it);
		it.hw_type = ARP_HW_ETH; it.proto_type = 16'hFFFF; send_item(it);
		it.proto_type = ARP_PROTO_IP; it.hw_addr_len = 8'hFF; send_item(it);
		it.hw_addr_len = ARP_HLEN; it.proto_addr_len = 8'hFF; send_item(it);
		it.proto_addr_len = ARP_PLEN; it.arp_opcode = 16'hFFFF; send_item(it);
		it.arp_opcode = 16'd0; send_item(it);
		it = tick(); it.cmd = CMD_NONE; send_item(it);      // ignored command
		for (int i = 0; i < NP + 1; i++) send_item(pkt(32'hA000_0000 + i, i[7:0])); // full
		repeat (3) send_item(tick());                      // age out both tables
		send_item(pkt(32'h1, 8'h11));
		drain();
	endtask

	task automatic test_cache_full();
		write_reg(REG_ENTRY_LT, 48'hFFFF);
		write_reg(REG_PEND_LT, 48'hFFFF);
		for (int i = 0; i < NC; i++) begin
			send_item(good_arp(OP_REPLY, 32'hB000_0000 + i, 48'hC0 + i, '0));
			if (i % 5 == 0) send_item(tick());
		end
		send_item(good_arp(OP_REPLY, 32'hB100_0000, 48'hEE, '0)); // evicts oldest
		for (int i = 0; i < NC; i++) send_item(pkt(32'hB000_0000 + i, i[7:0]));
		drain();
		write_reg(REG_ENTRY_LT, 48'd0);                      // expires on next tick
		write_reg(REG_PEND_LT, 48'd0);
		send_item(tick());
		send_item(pkt(32'hB100_0000, 8'h01));
		drain();
	endtask

	task automatic test_random(int n, bit quiet);
		arc_item_t it;
		int k;
		calm = quiet;
		for (int j = 0; j < n; j++) begin
			it = '0;
			for (int b = 0; b < $bits(it); b += 32) it = (it << 32) | $urandom;
			k = $urandom_range(99);
			if (k < 40) begin
				it = good_arp(16'($urandom_range(1, 2)), ip_pool[$urandom_range(7)],
					48'({$urandom, $urandom}), ($urandom_range(2) == 0) ? my_ip : $urandom);
				it.frame_len = 11'($urandom_range(ARP_HDR_LEN, 1500));
			end else if (k < 75) begin
				it = pkt(ip_pool[$urandom_range(7)], 8'($urandom));
			end else if (k < 88) begin
				it = tick();
			end else if (k < 90) begin
				it.cmd = CMD_NONE;
			end else begin
				it.cmd = CMD_ARP;
				if ($urandom_range(1)) it.frame_len = 11'($urandom_range(27));
			end
			if (it.cmd == CMD_NONE) j--;
			send_item(it);
		end
		calm = 0;
		drain();
	endtask

	task automatic new_pool();
		for (int i = 0; i < 8; i++) ip_pool[i] = (i == 7) ? $urandom : ($urandom & 32'hFFF0_0000) | i;
	endtask

	initial begin
		model_reset();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_cache_full();
		new_pool();
		write_reg(REG_LOCAL_IP, {16'h0, ip_pool[3]});
		write_reg(REG_LOCAL_MAC, 48'({$urandom, $urandom}));
		write_reg(REG_ENTRY_LT, 48'd8);
		write_reg(REG_PEND_LT, 48'd3);
		test_random(600, 0);
		test_random(300, 1);
		new_pool();
		write_reg(REG_ENTRY_LT, 48'd1);
		write_reg(REG_PEND_LT, 48'hFFFF);
		write_reg(REG_LOCAL_IP, 48'd0);
		test_random(500, 0);
		new_pool();
		write_reg(REG_ENTRY_LT, 48'hFFFF);
		write_reg(REG_PEND_LT, 48'd1);
		test_random(500, 0);
		if (!failed) $display("** arp_resolver_cache_unit: PASSED **");
		else $display("** arp_resolver_cache_unit: FAILED **");
		$finish;
	end

	initial begin
		#20000000;
		$display("** arp_resolver_cache_unit: FAILED **");
		$finish;
	end
endmodule
